>>> rtl/core/oal_pkg.sv
// ============================================================================
// oal_pkg
// Shared types and constants for the ordered array list core.
// ============================================================================
package oal_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 7;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;
    localparam int CMP_W  = (CNT_W > CAP_W) ? ((CNT_W > POS_W) ? CNT_W : POS_W)
                                            : ((CAP_W > POS_W) ? CAP_W : POS_W);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] list_length;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_TAKE = 4'd1,
        OP_PREP = 4'd2,
        OP_CAP  = 4'd3,
        OP_UP   = 4'd4,
        OP_PUT  = 4'd5,
        OP_DN   = 4'd6,
        OP_ZERO = 4'd7,
        OP_LOAD = 4'd8
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic del_bad;
        logic get_bad;
        logic up_more;
        logic dn_more;
        logic clr_last;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> rtl/core/oal_dp.sv
// ============================================================================
// oal_dp
// Datapath: slot memory, entry count, move pipeline and result register.
// ============================================================================
module oal_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oal_pkg::t_dp_cmd   i_cmd,
    output oal_pkg::t_dp_stat  o_stat,
    input  oal_pkg::t_in_item  i_in_item,
    input  logic [6:0]         i_cap,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output oal_pkg::t_out_item o_out_item
);
    import oal_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    t_in_item         r_item;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_tgt, n_tgt;
    logic [AW-1:0]    r_wa, n_wa;
    logic             r_wp, n_wp;
    t_status          r_status;
    logic [VAL_W-1:0] r_rv;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CMP_W-1:0] cap_x, cap_eff, cnt_x, pos_x;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    wa;
    logic [WIDTH-1:0] wd;

    always_comb begin
        cap_x   = CMP_W'(i_cap);
        cap_eff = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;
        cnt_x   = CMP_W'(r_count);
        pos_x   = CMP_W'(r_item.position);
    end

    always_comb begin
        o_stat.cmd      = r_item.cmd;
        o_stat.full     = (cnt_x >= cap_eff);
        o_stat.del_bad  = (pos_x >= cnt_x) || (pos_x >= cap_eff);
        o_stat.get_bad  = (pos_x >= cap_eff);
        o_stat.up_more  = (r_idx > r_tgt);
        o_stat.dn_more  = (r_idx < r_count);
        o_stat.clr_last = (r_idx == CNT_W'(DEPTH - 1));
        o_stat.out_busy = r_out_valid && i_out_stall;
    end

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_tgt   = r_tgt;
        n_wa    = r_wa;
        n_wp    = 1'b0;
        rd_addr = AW'(pos_x);
        case (i_cmd.op)
            OP_PREP: begin
                case (r_item.cmd) inside
                    CMD_INSERT: begin
                        n_idx = r_count;
                        n_tgt = (pos_x > cnt_x) ? r_count : CNT_W'(pos_x);
                    end
                    CMD_DELETE, CMD_GET: begin
                        n_idx = CNT_W'(pos_x + CMP_W'(1));
                    end
                    default: begin
                        n_idx = '0;
                    end
                endcase
            end
            OP_UP: begin
                if (r_idx > r_tgt) begin
                    rd_addr = AW'(r_idx - CNT_W'(1));
                    n_wa    = AW'(r_idx);
                    n_wp    = 1'b1;
                    n_idx   = r_idx - CNT_W'(1);
                end
            end
            OP_DN: begin
                if (r_idx < r_count) begin
                    rd_addr = AW'(r_idx);
                    n_wa    = AW'(r_idx - CNT_W'(1));
                    n_wp    = 1'b1;
                    n_idx   = r_idx + CNT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_PUT: begin
                n_count = r_count + CNT_W'(1);
            end
            OP_ZERO: begin
                n_idx   = r_idx + CNT_W'(1);
                n_count = '0;
            end
            default: ;
        endcase
    end

    // one write port: pending move, then value store, then zero fill
    always_comb begin
        we = 1'b0;
        wa = r_wa;
        wd = r_rd_data;
        if (r_wp) begin
            we = 1'b1;
        end else if (i_cmd.op == OP_PUT) begin
            we = 1'b1;
            wa = AW'(r_tgt);
            wd = WIDTH'(r_item.element_value);
        end else if (i_cmd.op == OP_ZERO) begin
            we = 1'b1;
            wa = AW'(r_idx);
            wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_wp        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_wp    <= n_wp;
            if (i_cmd.op == OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt <= n_tgt;
        r_wa  <= n_wa;
        if (i_cmd.op == OP_TAKE) begin
            r_item <= i_in_item;
        end
        if (i_cmd.op == OP_PREP) begin
            r_status <= i_cmd.status;
            r_rv     <= '0;
        end
        if (i_cmd.op == OP_CAP) begin
            r_rv <= VAL_W'(r_rd_data);
        end
        if (i_cmd.op == OP_LOAD) begin
            r_out.status      <= r_status;
            r_out.read_value  <= r_rv;
            r_out.list_length <= LEN_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> rtl/core/oal_ctrl.sv
// ============================================================================
// oal_ctrl
// Controller: sequences each command through the datapath.
// ============================================================================
module oal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  oal_pkg::t_dp_stat i_stat,
    output oal_pkg::t_dp_cmd  o_cmd
);
    import oal_pkg::*;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_PREP = 9'b000000100,
        S_CAP  = 9'b000001000,
        S_UP   = 9'b000010000,
        S_PUT  = 9'b000100000,
        S_DN   = 9'b001000000,
        S_ZERO = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_ZERO;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_UP;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.del_bad) begin
                            o_cmd.status = ST_RANGE;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_CAP;
                        end
                    end
                    CMD_GET: begin
                        if (i_stat.get_bad) begin
                            o_cmd.status = ST_RANGE;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_CAP;
                        end
                    end
                    default: begin
                        n_state = S_ZERO;
                    end
                endcase
            end
            S_CAP: begin
                o_cmd.op = OP_CAP;
                n_state  = (i_stat.cmd == CMD_DELETE) ? S_DN : S_DONE;
            end
            S_UP: begin
                o_cmd.op = OP_UP;
                if (!i_stat.up_more) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.op = OP_PUT;
                n_state  = S_DONE;
            end
            S_DN: begin
                o_cmd.op = OP_DN;
                if (!i_stat.dn_more) begin
                    n_state = S_DONE;
                end
            end
            S_ZERO: begin
                o_cmd.op = OP_ZERO;
                if (i_stat.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/ordered_array_list_core.sv
// ============================================================================
// ordered_array_list_core
// Ordered array list with insert, delete, get and clear commands.
// ============================================================================
// Each item gives one result. Items are handled one at a time; the slot
// memory has one write port and moves one entry per cycle, so an insert or
// delete takes longer the more entries lie above its position, and a clear
// zeroes every slot. An insert, delete or get that is rejected skips the
// move. A result waiting on a stalled output does not hold up work on the
// next item; the next result is loaded once the output is free. After reset
// the core zeroes the memory before it takes the first item; capacity writes
// are taken during that pass. Capacity sits at byte address 0 and resets to
// 64.
module ordered_array_list_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  oal_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output oal_pkg::t_out_item                o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [oal_pkg::APB_AW-1:0]        paddr,
    input  logic [oal_pkg::APB_DW-1:0]        pwdata,
    output logic [oal_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import oal_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             cap_sel;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    assign cap_sel = (paddr[APB_AW-1:2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && cap_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = cap_sel ? APB_DW'(r_capacity) : '0;
    assign pready = 1'b1;

    oal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    oal_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_item   (i_in_item),
        .i_cap       (r_capacity),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/core/oal_checker.sv
// ============================================================================
// oal_checker
// Port-level checks for the ordered array list core.
// ============================================================================
module oal_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input oal_pkg::t_out_item o_out_item
);
    import oal_pkg::*;

    // one item in flight: stall rises right after an accept
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item accept");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |-> (o_out_item.read_value == '0))
        else $error("error result carries nonzero value");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CMP_W'(o_out_item.list_length) <= CMP_W'(DEPTH)))
        else $error("list length beyond depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output item changed");

endmodule

bind ordered_array_list_core oal_checker u_oal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
